### sv/hdt_pkg.sv
// ============================================================================
// hdt_pkg
// Shared constants and helpers for the 4x4 Hadamard layer transform.
// ============================================================================
package hdt_pkg;

    // Block geometry.
    localparam int ROWS        = 4;
    localparam int COLS        = 4;
    localparam int LAYERS      = 16;
    localparam int STORED_ROWS = ROWS - 1;

    // Coefficients are the signed sum divided by 16, truncated toward zero.
    localparam int DIV_SHIFT = 4;

    // Output field widths.
    localparam int COEF_BITS  = 16;
    localparam int GROUP_BITS = 2;
    localparam int MASK_BITS  = 16;

    // Reset value of the layer enable mask: every layer computed.
    localparam logic [MASK_BITS-1:0] MASK_RESET = 16'hFFFF;

    // Index of the final layer group of a block.
    localparam logic [GROUP_BITS-1:0] LAST_GROUP = 2'd3;

    // Row count value on which the final row of a block arrives.
    localparam logic [1:0] LAST_ROW = 2'd3;

    // Sign of element i under 4-point basis pattern p. Bit 0 of the pattern
    // flips elements whose index has bit 1 set, bit 1 flips those with bit 0.
    // The 2-D basis is separable: columns use layer bits {2,0}, rows {3,1}.
    function automatic logic sign_neg(input logic [1:0] p, input logic [1:0] i);
        return (p[0] & i[1]) ^ (p[1] & i[0]);
    endfunction

endpackage

### sv/hdt_row_xform.sv
// ============================================================================
// hdt_row_xform
// Horizontal 4-point transform of one incoming row of residual samples.
// ============================================================================
module hdt_row_xform #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic        [hdt_pkg::COEF_BITS-1:0] sample [hdt_pkg::COLS],
    output logic signed [SAMPLE_BITS+1:0]        h      [hdt_pkg::COLS]
);
    import hdt_pkg::*;

    localparam int HW = SAMPLE_BITS + 2;

    logic signed [HW-1:0] x   [COLS];
    logic signed [HW-1:0] acc;

    // Keep the low sample bits as a two's complement value, then form the
    // four column patterns of the row.
    always_comb begin
        acc = '0;
        for (int c = 0; c < COLS; c++) begin
            x[c] = HW'(signed'(sample[c][SAMPLE_BITS-1:0]));
        end
        for (int k = 0; k < COLS; k++) begin
            acc = '0;
            for (int c = 0; c < COLS; c++) begin
                acc = sign_neg(2'(k), 2'(c)) ? acc - x[c] : acc + x[c];
            end
            h[k] = acc;
        end
    end

endmodule

### sv/hdt_block.sv
// ============================================================================
// hdt_block
// Row counter, store of the first three transformed rows, vertical transform
// and the block register that holds the sixteen masked layer sums.
// ============================================================================
module hdt_block #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [SAMPLE_BITS+1:0]       h        [hdt_pkg::COLS],
    input  logic                                cfg_we,
    input  logic        [hdt_pkg::MASK_BITS-1:0] cfg_wdata,
    input  logic                                blk_free,
    output logic                                blk_load,
    output logic signed [SAMPLE_BITS+3:0]       sums     [hdt_pkg::LAYERS]
);
    import hdt_pkg::*;

    localparam int HW = SAMPLE_BITS + 2;
    localparam int SW = SAMPLE_BITS + 4;

    logic [1:0]           row_count_reg;
    logic [1:0]           row_count_next;
    logic [MASK_BITS-1:0] mask_reg;
    logic signed [HW-1:0] row_store_reg [STORED_ROWS][COLS];
    logic signed [SW-1:0] sum_reg       [LAYERS];
    logic signed [SW-1:0] sum_next      [LAYERS];
    logic signed [HW-1:0] row_val;
    logic signed [SW-1:0] acc;
    logic                 accept;
    logic                 last_row;

    // The final row may enter only when the output side can take a block.
    assign last_row = (row_count_reg == LAST_ROW);
    assign in_ready = !last_row || blk_free;
    assign accept   = in_valid && in_ready;
    assign blk_load = accept && last_row;
    assign sums     = sum_reg;

    // Row counter wraps after the fourth row of a block.
    always_comb begin
        row_count_next = row_count_reg;
        if (accept) begin
            row_count_next = row_count_reg + 2'd1;
        end
    end

    // Vertical transform over three stored rows and the arriving row.
    always_comb begin
        acc     = '0;
        row_val = '0;
        for (int l = 0; l < LAYERS; l++) begin
            acc = '0;
            for (int r = 0; r < ROWS; r++) begin
                if (r < STORED_ROWS) begin
                    row_val = row_store_reg[r][{l[2], l[0]}];
                end else begin
                    row_val = h[{l[2], l[0]}];
                end
                acc = sign_neg({l[3], l[1]}, 2'(r)) ? acc - SW'(row_val)
                                                    : acc + SW'(row_val);
            end
            sum_next[l] = mask_reg[l] ? acc : '0;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_count_reg <= '0;
            mask_reg      <= MASK_RESET;
        end else begin
            row_count_reg <= row_count_next;
            if (cfg_we) begin
                mask_reg <= cfg_wdata;
            end
        end
    end

    // Row store and block register carry payload only.
    always_ff @(posedge aclk) begin
        if (accept && !last_row) begin
            row_store_reg[row_count_reg] <= h;
        end
        if (blk_load) begin
            sum_reg <= sum_next;
        end
    end

endmodule

### sv/hdt_out_stage.sv
// ============================================================================
// hdt_out_stage
// Group sequencer, divide by sixteen and the result register of the m_
// channel. One group of four coefficients leaves per transaction.
// ============================================================================
module hdt_out_stage #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 blk_load,
    output logic                                 blk_free,
    input  logic signed [SAMPLE_BITS+3:0]        sums        [hdt_pkg::LAYERS],
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [hdt_pkg::COEF_BITS-1:0]  m_coef      [hdt_pkg::COLS],
    output logic        [hdt_pkg::GROUP_BITS-1:0] m_layer_group,
    output logic                                 m_last_group
);
    import hdt_pkg::*;

    localparam int SW = SAMPLE_BITS + 4;

    logic                         busy_reg;
    logic                         busy_next;
    logic [GROUP_BITS-1:0]        grp_reg;
    logic [GROUP_BITS-1:0]        grp_next;
    logic                         m_valid_reg;
    logic                         m_valid_next;
    logic signed [COEF_BITS-1:0]  coef_reg  [COLS];
    logic signed [COEF_BITS-1:0]  coef_next [COLS];
    logic [GROUP_BITS-1:0]        group_reg;
    logic                         last_reg;
    logic                         advance;
    logic signed [SW-1:0]         sel;
    logic signed [SW-1:0]         adj;
    logic signed [SW-1:0]         quo;

    // The result register moves when it is empty or being taken.
    assign advance  = !m_valid_reg || m_ready;
    assign blk_free = !busy_reg || ((grp_reg == LAST_GROUP) && advance);

    // Group sequencer: a new block restarts at group zero.
    always_comb begin
        busy_next    = busy_reg;
        grp_next     = grp_reg;
        m_valid_next = m_valid_reg;
        if (advance) begin
            m_valid_next = busy_reg;
            if (busy_reg) begin
                grp_next = grp_reg + 2'd1;
                if (grp_reg == LAST_GROUP) begin
                    busy_next = 1'b0;
                end
            end
        end
        if (blk_load) begin
            busy_next = 1'b1;
            grp_next  = '0;
        end
    end

    // Divide the four selected sums by sixteen, truncating toward zero.
    always_comb begin
        sel = '0;
        adj = '0;
        quo = '0;
        for (int j = 0; j < COLS; j++) begin
            sel          = sums[{grp_reg, 2'(j)}];
            adj          = sel + (sel[SW-1] ? SW'((1 << DIV_SHIFT) - 1) : SW'(0));
            quo          = adj >>> DIV_SHIFT;
            coef_next[j] = COEF_BITS'(quo);
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            grp_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            grp_reg     <= grp_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge aclk) begin
        if (advance && busy_reg) begin
            coef_reg  <= coef_next;
            group_reg <= grp_reg;
            last_reg  <= (grp_reg == LAST_GROUP);
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_coef        = coef_reg;
    assign m_layer_group = group_reg;
    assign m_last_group  = last_reg;

    // A block is loaded only when the previous one has drained.
    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        blk_load |-> blk_free)
        else $error("block loaded while groups are still pending");

    // A loaded block starts at group zero in the next cycle.
    a_load_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        blk_load |=> (busy_reg && grp_reg == '0))
        else $error("group sequencer did not restart on block load");

    // A stalled sequencer keeps its place.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && !advance && !blk_load) |=> (busy_reg && $stable(grp_reg)))
        else $error("group sequencer moved while the result was stalled");

    // The final-group flag marks exactly group three.
    a_last_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (last_reg == (group_reg == LAST_GROUP)))
        else $error("last_group does not match layer_group");

endmodule

### sv/hadamard_4x4_layer_transform.sv
// ============================================================================
// hadamard_4x4_layer_transform
// Forward 4x4 directional decomposition of residual blocks into 16 layers.
// ============================================================================
// Usage:
//   The s_ channel takes one row of four signed samples per transaction; four
//   consecutive rows form one 4x4 block. Each row is transformed horizontally
//   as it arrives and the first three are kept. The fourth row completes the
//   vertical transform, and the block yields four m_ transactions, each with
//   the coefficients of layers 4*g .. 4*g+3, m_layer_group = g in order 0..3
//   and m_last_group set on group 3.
//   The accepted fourth row loads the block register; group 0 then moves
//   from it into the result register and raises m_valid, and groups 1..3
//   follow one per cycle while m_ready is high.
//   Throughput: one row per cycle in and one result per cycle out, sustained while m_ready stays high.
//   The block register holding the sixteen sums is the only resource shared
//   between blocks; the fourth row of the next block enters in the cycle
//   that the last group moves into the result register.
//   Stalls: while m_ready is low the result holds, rows 0..2 of the next
//   block are still taken, and s_ready drops only for a fourth row that
//   finds the block register still occupied.
//   Reset (aresetn, synchronous, active low): row count cleared, no result
//   pending, layer enable mask set to all ones. cfg_we writes the mask.
// ============================================================================
module hadamard_4x4_layer_transform #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  logic        [hdt_pkg::MASK_BITS-1:0]  cfg_wdata,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [hdt_pkg::COEF_BITS-1:0]  s_sample_0,
    input  logic signed [hdt_pkg::COEF_BITS-1:0]  s_sample_1,
    input  logic signed [hdt_pkg::COEF_BITS-1:0]  s_sample_2,
    input  logic signed [hdt_pkg::COEF_BITS-1:0]  s_sample_3,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [hdt_pkg::COEF_BITS-1:0]  m_coef_first,
    output logic signed [hdt_pkg::COEF_BITS-1:0]  m_coef_second,
    output logic signed [hdt_pkg::COEF_BITS-1:0]  m_coef_third,
    output logic signed [hdt_pkg::COEF_BITS-1:0]  m_coef_fourth,
    output logic        [hdt_pkg::GROUP_BITS-1:0] m_layer_group,
    output logic                                 m_last_group
);
    import hdt_pkg::*;

    logic        [COEF_BITS-1:0]   samples [COLS];
    logic signed [SAMPLE_BITS+1:0] h       [COLS];
    logic signed [SAMPLE_BITS+3:0] sums    [LAYERS];
    logic signed [COEF_BITS-1:0]   coef    [COLS];
    logic                          blk_load;
    logic                          blk_free;

    // Gather the row into an array for the horizontal transform.
    assign samples[0] = s_sample_0;
    assign samples[1] = s_sample_1;
    assign samples[2] = s_sample_2;
    assign samples[3] = s_sample_3;

    hdt_row_xform #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_row_xform (
        .sample (samples),
        .h      (h)
    );

    hdt_block #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_block (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .h         (h),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .blk_free  (blk_free),
        .blk_load  (blk_load),
        .sums      (sums)
    );

    hdt_out_stage #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_out_stage (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .blk_load      (blk_load),
        .blk_free      (blk_free),
        .sums          (sums),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_coef        (coef),
        .m_layer_group (m_layer_group),
        .m_last_group  (m_last_group)
    );

    // Spread the result coefficients onto their ports.
    assign m_coef_first  = coef[0];
    assign m_coef_second = coef[1];
    assign m_coef_third  = coef[2];
    assign m_coef_fourth = coef[3];

endmodule

### tb/tb_hadamard_4x4_layer_transform.sv
// ============================================================================
// tb_hadamard_4x4_layer_transform
// Self-checking testbench for the 4x4 Hadamard layer transform.
// ============================================================================
// Rows of four signed samples are streamed into the s_ channel with random
// bursts and gaps while the m_ channel stalls on its own pattern. A predictor
// in the testbench rebuilds each 4x4 block, forms the sixteen masked layer
// coefficients and queues the four expected layer groups, which the checker
// compares field by field against every m_ transaction. Directed blocks hit
// the sample extremes, truncation toward zero and the layer enable mask, and
// random phases run under several mask settings and idling profiles.
// ============================================================================
module tb_hadamard_4x4_layer_transform;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 8;

    typedef struct {
        logic [hdt_pkg::COEF_BITS-1:0]  coef_first;
        logic [hdt_pkg::COEF_BITS-1:0]  coef_second;
        logic [hdt_pkg::COEF_BITS-1:0]  coef_third;
        logic [hdt_pkg::COEF_BITS-1:0]  coef_fourth;
        logic [hdt_pkg::GROUP_BITS-1:0] layer_group;
        logic                           last_group;
    } coef_group_t;

    logic                                 aclk;
    logic                                 aresetn;
    logic                                 cfg_we;
    logic        [hdt_pkg::MASK_BITS-1:0] cfg_wdata;
    logic                                 s_valid;
    logic                                 s_ready;
    logic signed [hdt_pkg::COEF_BITS-1:0] s_sample_0;
    logic signed [hdt_pkg::COEF_BITS-1:0] s_sample_1;
    logic signed [hdt_pkg::COEF_BITS-1:0] s_sample_2;
    logic signed [hdt_pkg::COEF_BITS-1:0] s_sample_3;
    logic                                 m_valid;
    logic                                 m_ready;
    logic signed [hdt_pkg::COEF_BITS-1:0] m_coef_first;
    logic signed [hdt_pkg::COEF_BITS-1:0] m_coef_second;
    logic signed [hdt_pkg::COEF_BITS-1:0] m_coef_third;
    logic signed [hdt_pkg::COEF_BITS-1:0] m_coef_fourth;
    logic        [hdt_pkg::GROUP_BITS-1:0] m_layer_group;
    logic                                 m_last_group;

    // Predictor state: held rows of the current block and the active mask.
    int                            held_rows [12];
    int                            rows_held;
    int                            block_samples [16];
    logic [hdt_pkg::MASK_BITS-1:0] layer_mask;
    coef_group_t                   pending_groups [$];

    int  mismatch_count;
    int  cycle_count;
    int  burst_left;
    bit  tx_idle_on;
    bit  rx_stall_on;

    hadamard_4x4_layer_transform #(
        .SAMPLE_BITS(16)
    ) uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_sample_0   (s_sample_0),
        .s_sample_1   (s_sample_1),
        .s_sample_2   (s_sample_2),
        .s_sample_3   (s_sample_3),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_coef_first (m_coef_first),
        .m_coef_second(m_coef_second),
        .m_coef_third (m_coef_third),
        .m_coef_fourth(m_coef_fourth),
        .m_layer_group(m_layer_group),
        .m_last_group (m_last_group)
    );

    // Clock generation.
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // A sample counts negative in a layer when this parity of layer, row and
    // column bits is odd.
    function automatic bit layer_sign_neg(input int l, input int r, input int c);
        return 1'(((l & 1) & (c >> 1) & 1) ^ ((l >> 1) & (r >> 1) & 1)
             ^ ((l >> 2) & c & 1) ^ ((l >> 3) & r & 1));
    endfunction

    // Masked coefficient of one layer over the block in block_samples.
    function automatic logic [hdt_pkg::COEF_BITS-1:0] layer_coef(input int l);
        int sum;
        sum = 0;
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                if (layer_sign_neg(l, r, c)) begin
                    sum -= block_samples[r*4 + c];
                end else begin
                    sum += block_samples[r*4 + c];
                end
            end
        end
        // Integer division truncates toward zero, as the block does.
        return layer_mask[l] ? hdt_pkg::COEF_BITS'(sum / 16) : '0;
    endfunction

    // Update the predictor with one accepted row; the fourth row of a block
    // queues the four expected layer groups.
    task automatic absorb_row(input logic signed [15:0] s0, input logic signed [15:0] s1,
                              input logic signed [15:0] s2, input logic signed [15:0] s3);
        logic [hdt_pkg::COEF_BITS-1:0] coefs [16];
        coef_group_t                   grp;
        if (rows_held < 3) begin
            held_rows[rows_held*4 + 0] = int'(s0);
            held_rows[rows_held*4 + 1] = int'(s1);
            held_rows[rows_held*4 + 2] = int'(s2);
            held_rows[rows_held*4 + 3] = int'(s3);
            rows_held++;
        end else begin
            for (int i = 0; i < 12; i++) begin
                block_samples[i] = held_rows[i];
            end
            block_samples[12] = int'(s0);
            block_samples[13] = int'(s1);
            block_samples[14] = int'(s2);
            block_samples[15] = int'(s3);
            for (int l = 0; l < hdt_pkg::LAYERS; l++) begin
                coefs[l] = layer_coef(l);
            end
            for (int g = 0; g < 4; g++) begin
                grp.coef_first  = coefs[4*g + 0];
                grp.coef_second = coefs[4*g + 1];
                grp.coef_third  = coefs[4*g + 2];
                grp.coef_fourth = coefs[4*g + 3];
                grp.layer_group = hdt_pkg::GROUP_BITS'(g);
                grp.last_group  = (hdt_pkg::GROUP_BITS'(g) == hdt_pkg::LAST_GROUP);
                pending_groups.push_back(grp);
            end
            rows_held = 0;
        end
    endtask

    // Send one row transaction, with a random gap at the start of each burst.
    task automatic send_row(input logic [15:0] s0, input logic [15:0] s1,
                            input logic [15:0] s2, input logic [15:0] s3);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = tx_idle_on ? $urandom_range(0, 6) : 0;
            if (gap > 0) begin
                @(negedge aclk);
                s_valid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        burst_left--;
        @(negedge aclk);
        s_valid    <= 1'b1;
        s_sample_0 <= s0;
        s_sample_1 <= s1;
        s_sample_2 <= s2;
        s_sample_3 <= s3;
        do @(posedge aclk); while (!s_ready);
        absorb_row(s0, s1, s2, s3);
    endtask

    // Send a whole block, row by row.
    task automatic send_block(input logic [15:0] blk [16]);
        for (int r = 0; r < 4; r++) begin
            send_row(blk[r*4], blk[r*4 + 1], blk[r*4 + 2], blk[r*4 + 3]);
        end
    endtask

    // Stop sending, wait for every expected group, then let the block settle.
    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_groups.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write the layer enable mask while the block is idle.
    task automatic set_layer_mask(input logic [hdt_pkg::MASK_BITS-1:0] value);
        wait_idle();
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        layer_mask = value;
    endtask

    // Random sample: mostly full range, with small values and extremes mixed in.
    function automatic logic [15:0] random_sample();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick <= 5) begin
            return 16'($urandom);
        end else if (pick <= 7) begin
            return 16'($urandom_range(0, 64) - 32);
        end else if (pick == 8) begin
            return $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
        end
        return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        $display("MISMATCH at %0t: %s got %0d expected %0d", $time, what, got, want);
    endtask

    // Receiver: ready runs and stalls of random length, now and then a long stall.
    initial begin
        bit level;
        int run;
        m_ready = 1'b0;
        level = 1'b0;
        forever begin
            if (!rx_stall_on) begin
                @(negedge aclk);
                m_ready <= 1'b1;
            end else begin
                level = ~level;
                if (level) begin
                    run = $urandom_range(1, 6);
                end else if ($urandom_range(0, 9) == 0) begin
                    run = $urandom_range(12, 20);
                end else begin
                    run = $urandom_range(1, 4);
                end
                repeat (run) begin
                    @(negedge aclk);
                    m_ready <= level;
                end
            end
        end
    end

    // Compare each result transaction with the oldest expected layer group.
    always @(posedge aclk) begin
        coef_group_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_groups.size() == 0) begin
                report_mismatch("result with none expected, group", int'(m_layer_group), -1);
            end else begin
                want = pending_groups.pop_front();
                if (m_coef_first !== want.coef_first)
                    report_mismatch("coef_first", int'(m_coef_first),
                                    int'($signed(want.coef_first)));
                if (m_coef_second !== want.coef_second)
                    report_mismatch("coef_second", int'(m_coef_second),
                                    int'($signed(want.coef_second)));
                if (m_coef_third !== want.coef_third)
                    report_mismatch("coef_third", int'(m_coef_third),
                                    int'($signed(want.coef_third)));
                if (m_coef_fourth !== want.coef_fourth)
                    report_mismatch("coef_fourth", int'(m_coef_fourth),
                                    int'($signed(want.coef_fourth)));
                if (m_layer_group !== want.layer_group)
                    report_mismatch("layer_group", int'(m_layer_group),
                                    int'(want.layer_group));
                if (m_last_group !== want.last_group)
                    report_mismatch("last_group", int'(m_last_group), int'(want.last_group));
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Full-scale samples, the largest coefficients of both signs, and a
    // small negative sum that must truncate toward zero.
    task automatic test_extremes();
        logic [15:0] blk [16];
        foreach (blk[i]) blk[i] = 16'h7FFF;
        send_block(blk);
        foreach (blk[i]) blk[i] = layer_sign_neg(15, i / 4, i % 4) ? 16'h8000 : 16'h7FFF;
        send_block(blk);
        foreach (blk[i]) blk[i] = layer_sign_neg(15, i / 4, i % 4) ? 16'h7FFF : 16'h8000;
        send_block(blk);
        foreach (blk[i]) blk[i] = 16'h0000;
        blk[6] = 16'hFFEF;
        send_block(blk);
    endtask

    // All layers disabled, then a mask change in the middle of a block.
    task automatic test_layer_mask();
        logic [15:0] blk [16];
        set_layer_mask(16'h0000);
        foreach (blk[i]) blk[i] = random_sample();
        send_block(blk);
        for (int r = 0; r < 3; r++) begin
            send_row(random_sample(), random_sample(), random_sample(), random_sample());
        end
        // The mask in force at the fourth row covers the whole block.
        set_layer_mask(16'hA55A);
        send_row(random_sample(), random_sample(), random_sample(), random_sample());
    endtask

    // Random blocks in phases with different masks and idling profiles.
    task automatic test_random_blocks();
        logic [15:0]                   blk [16];
        logic [hdt_pkg::MASK_BITS-1:0] phase_mask [6];
        phase_mask[0] = hdt_pkg::MASK_RESET;
        phase_mask[1] = 16'($urandom);
        phase_mask[2] = 16'h0001;
        phase_mask[3] = 16'h8000;
        phase_mask[4] = 16'($urandom);
        phase_mask[5] = hdt_pkg::MASK_RESET;
        for (int p = 0; p < 6; p++) begin
            set_layer_mask(phase_mask[p]);
            tx_idle_on  = (p % 3) != 0;
            rx_stall_on = (p % 3) != 1;
            for (int b = 0; b < 20; b++) begin
                foreach (blk[i]) blk[i] = random_sample();
                send_block(blk);
            end
        end
    endtask

    // Test sequence.
    initial begin
        aresetn        = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        s_valid        = 1'b0;
        s_sample_0     = '0;
        s_sample_1     = '0;
        s_sample_2     = '0;
        s_sample_3     = '0;
        rows_held      = 0;
        layer_mask     = hdt_pkg::MASK_RESET;
        mismatch_count = 0;
        cycle_count    = 0;
        burst_left     = 0;
        tx_idle_on     = 1'b1;
        rx_stall_on    = 1'b1;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        set_layer_mask(hdt_pkg::MASK_RESET);
        test_extremes();
        test_layer_mask();
        test_random_blocks();
        wait_idle();

        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
